### src/gdrc_pkg.sv
// Shared types, constants and helpers of the grid DDA column raycaster.
// No dependencies; every other file except gdrc_div uses this package by scoped names.
`default_nettype none
package gdrc_pkg;

	localparam int MAP_DIM_DEF   = 32;
	localparam int MAX_STEPS_DEF = 64;

	localparam int          DIV_NW    = 33;
	localparam logic [32:0] ONE_SHL32 = 33'h1_0000_0000;
	localparam logic [15:0] LINE_MAX  = 16'hFFFF;

	localparam logic [20:0] RST_POS_X   = 21'd1441792;
	localparam logic [20:0] RST_POS_Y   = 21'd786432;
	localparam logic [18:0] RST_DIR_X   = 19'h70000;
	localparam logic [18:0] RST_DIR_Y   = 19'd0;
	localparam logic [18:0] RST_PLANE_X = 19'd0;
	localparam logic [18:0] RST_PLANE_Y = 19'd43254;
	localparam logic [10:0] RST_COLS    = 11'd600;
	localparam logic [10:0] RST_ROWS    = 11'd600;

	typedef enum logic [3:0] {
		REG_POS_X   = 4'd0,
		REG_POS_Y   = 4'd1,
		REG_DIR_X   = 4'd2,
		REG_DIR_Y   = 4'd3,
		REG_PLANE_X = 4'd4,
		REG_PLANE_Y = 4'd5,
		REG_COLS    = 4'd6,
		REG_ROWS    = 4'd7
	} reg_idx_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_CAST  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic        cmd;
		logic [4:0]  cell_x;
		logic [4:0]  cell_y;
		logic [2:0]  cell_code;
		logic [9:0]  column;
	} item_t;

	typedef struct packed {
		logic [9:0]  out_column;
		logic [9:0]  stripe_top;
		logic [9:0]  stripe_bottom;
		logic [23:0] wall_colour;
		logic        hit_side;
		logic        no_hit;
	} result_t;

	typedef struct packed {
		logic [20:0]        pos_x;
		logic [20:0]        pos_y;
		logic signed [18:0] dir_x;
		logic signed [18:0] dir_y;
		logic signed [18:0] plane_x;
		logic signed [18:0] plane_y;
		logic [10:0]        cols;
		logic [10:0]        rows;
	} cfg_t;

	// back end status toward the front end
	typedef struct packed {
		logic clearing;
		logic pop;
	} bk_stat_t;

	function automatic logic [23:0] wall_rgb(input logic [2:0] code);
		logic [23:0] c;
		unique case (code)
			3'd1:    c = 24'hFF0000;
			3'd2:    c = 24'h32CD32;
			3'd3:    c = 24'h0000FF;
			3'd0,
			3'd4:    c = 24'h000000;
			default: c = 24'hFFFF00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

### src/gdrc_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses nothing from the package; instantiated by gdrc_back.
`default_nettype none
module gdrc_div #(
	parameter int NW = 33,
	parameter int DW = 42
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [NW-1:0]      quot
);
	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    num_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic             fits;

	assign trial = {rem_q, num_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CNT_W'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			// shift in the next dividend bit, quotient bit enters at the bottom
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			num_q <= {num_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = num_q;
endmodule
`default_nettype wire

### src/gdrc_front.sv
// Front end: accepts items, drops writes outside the map, queues the rest.
// Depends on gdrc_pkg (item_t, bk_stat_t, CMD_CAST).
`default_nettype none
module gdrc_front #(
	parameter int MAP_DIM = gdrc_pkg::MAP_DIM_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire gdrc_pkg::item_t   item,
	output logic                   busy,
	input  wire gdrc_pkg::bk_stat_t bk_stat,
	output logic                   q_valid,
	output gdrc_pkg::item_t        q_item
);
	gdrc_pkg::item_t ent_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            accept;
	logic            keep;
	logic            push;
	logic            pop;

	assign busy   = (cnt_q == 2'd2) || bk_stat.clearing;
	assign accept = start && !busy;
	assign keep   = (item.cmd == gdrc_pkg::CMD_CAST) ||
	                ((32'(item.cell_x) < MAP_DIM) && (32'(item.cell_y) < MAP_DIM));
	assign push   = accept && keep;
	assign pop    = bk_stat.pop && (cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= item;
	end

	assign q_valid = cnt_q != 2'd0;
	assign q_item  = ent_q[rd_ptr_q];
endmodule
`default_nettype wire

### src/gdrc_back.sv
// Back end: map memory, clearing pass, camera setup, DDA walk and stripe math.
// Depends on gdrc_pkg and gdrc_div.
`default_nettype none
module gdrc_back #(
	parameter int MAP_DIM   = gdrc_pkg::MAP_DIM_DEF,
	parameter int MAX_STEPS = gdrc_pkg::MAX_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire gdrc_pkg::cfg_t     cfg,
	input  wire logic               q_valid,
	input  wire gdrc_pkg::item_t    q_item,
	output gdrc_pkg::bk_stat_t      bk_stat,
	output logic                    done,
	output gdrc_pkg::result_t       result
);
	localparam int DEPTH = MAP_DIM * MAP_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = 36 + $clog2(MAX_STEPS);
	localparam int CW    = 7 + $clog2(MAX_STEPS);
	localparam int STW   = $clog2(MAX_STEPS + 1);
	localparam int NW    = gdrc_pkg::DIV_NW;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CAM, S_MUL, S_RAY, S_DXGO, S_DXW, S_DYGO, S_DYW,
		S_SIDE, S_STEP, S_CHECK, S_PERP, S_LINE, S_FIN
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         clr_q;
	logic [2:0]            mem [DEPTH];
	logic [2:0]            rdata_q;
	logic                  div_go_q;
	logic [NW-1:0]         div_num_q;
	logic [SW-1:0]         div_den_q;
	logic                  div_done;
	logic [NW-1:0]         div_quot;
	logic [9:0]            column_q;
	logic signed [28:0]    cam_q;
	logic signed [47:0]    prod_x_q, prod_y_q;
	logic signed [32:0]    ray_x_q, ray_y_q;
	logic [32:0]           delta_x_q, delta_y_q;
	logic [SW-1:0]         side_x_q, side_y_q;
	logic signed [CW-1:0]  mx_q, my_q;
	logic [STW-1:0]        steps_q;
	logic                  side_q;
	logic                  inr_q;
	logic [2:0]            code_q;
	logic [15:0]           line_q;
	logic                  done_q;
	gdrc_pkg::result_t     res_q;

	logic [10:0]           cols_eff, rows_eff;
	logic signed [32:0]    trunc_x, trunc_y;
	logic [32:0]           mag_x, mag_y;
	logic [16:0]           f_x, f_y;
	logic                  adv_x;
	logic signed [CW-1:0]  nx, ny;
	logic                  in_range;
	logic [AW-1:0]         rd_addr;
	logic                  mem_we;
	logic [AW-1:0]         wr_addr;
	logic [2:0]            wr_data;
	logic [SW-1:0]         perp;
	logic [16:0]           tdiff, bsum;
	logic [9:0]            top_v, bot_v;
	logic [23:0]           colour;

	gdrc_div #(.NW(NW), .DW(SW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (div_go_q),
		.num   (div_num_q),
		.den   (div_den_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_comb begin
		cols_eff = (cfg.cols == 11'd0) ? 11'd1 : cfg.cols;
		if (cfg.rows == 11'd0)
			rows_eff = 11'd1;
		else if (cfg.rows > 11'd1024)
			rows_eff = 11'd1024;
		else
			rows_eff = cfg.rows;

		// divide by 65536, truncating toward zero
		trunc_x = prod_x_q[47] ? 33'((prod_x_q + 48'sd65535) >>> 16) : 33'(prod_x_q >>> 16);
		trunc_y = prod_y_q[47] ? 33'((prod_y_q + 48'sd65535) >>> 16) : 33'(prod_y_q >>> 16);
		mag_x = ray_x_q[32] ? 33'(-ray_x_q) : 33'(ray_x_q);
		mag_y = ray_y_q[32] ? 33'(-ray_y_q) : 33'(ray_y_q);
		f_x = ray_x_q[32] ? {1'b0, cfg.pos_x[15:0]} : 17'h10000 - {1'b0, cfg.pos_x[15:0]};
		f_y = ray_y_q[32] ? {1'b0, cfg.pos_y[15:0]} : 17'h10000 - {1'b0, cfg.pos_y[15:0]};

		adv_x = side_x_q < side_y_q;
		nx = mx_q;
		ny = my_q;
		if (adv_x)
			nx = ray_x_q[32] ? mx_q - CW'(1) : mx_q + CW'(1);
		else
			ny = ray_y_q[32] ? my_q - CW'(1) : my_q + CW'(1);
		in_range = (nx >= 0) && (32'(nx) < MAP_DIM) && (ny >= 0) && (32'(ny) < MAP_DIM);
		rd_addr = in_range ? AW'(32'(nx) * MAP_DIM + 32'(ny)) : '0;

		mem_we  = 1'b0;
		wr_addr = clr_q;
		wr_data = 3'd0;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == S_IDLE && q_valid && q_item.cmd == gdrc_pkg::CMD_WRITE) begin
			mem_we  = 1'b1;
			wr_addr = AW'(32'(q_item.cell_x) * MAP_DIM + 32'(q_item.cell_y));
			wr_data = q_item.cell_code;
		end

		perp  = side_q ? side_y_q - SW'(delta_y_q) : side_x_q - SW'(delta_x_q);
		tdiff = 17'({7'd0, rows_eff[10:1]}) - 17'({2'd0, line_q[15:1]});
		bsum  = 17'({7'd0, rows_eff[10:1]}) + 17'({2'd0, line_q[15:1]});
		top_v = tdiff[16] ? 10'd0 : tdiff[9:0];
		bot_v = (bsum >= 17'(rows_eff)) ? 10'(rows_eff - 11'd1) : bsum[9:0];
		colour = gdrc_pkg::wall_rgb(code_q);
		if (side_q)
			colour = colour >> 1;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_data;
		if (state_q == S_STEP)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			div_go_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			done_q   <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == DEPTH - 1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid && q_item.cmd == gdrc_pkg::CMD_CAST) begin
						column_q  <= q_item.column;
						div_num_q <= NW'({q_item.column, 17'd0});
						div_den_q <= SW'(cols_eff);
						div_go_q  <= 1'b1;
						state_q   <= S_CAM;
					end
				end
				S_CAM: begin
					if (div_done) begin
						cam_q   <= $signed({1'b0, div_quot[27:0]}) - 29'sd65536;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_x_q <= cfg.plane_x * cam_q;
					prod_y_q <= cfg.plane_y * cam_q;
					state_q  <= S_RAY;
				end
				S_RAY: begin
					ray_x_q <= 33'(cfg.dir_x) + trunc_x;
					ray_y_q <= 33'(cfg.dir_y) + trunc_y;
					state_q <= S_DXGO;
				end
				S_DXGO: begin
					if (mag_x == '0) begin
						delta_x_q <= gdrc_pkg::ONE_SHL32;
						state_q   <= S_DYGO;
					end else begin
						div_num_q <= gdrc_pkg::ONE_SHL32;
						div_den_q <= SW'(mag_x);
						div_go_q  <= 1'b1;
						state_q   <= S_DXW;
					end
				end
				S_DXW: begin
					if (div_done) begin
						delta_x_q <= div_quot;
						state_q   <= S_DYGO;
					end
				end
				S_DYGO: begin
					if (mag_y == '0) begin
						delta_y_q <= gdrc_pkg::ONE_SHL32;
						state_q   <= S_SIDE;
					end else begin
						div_num_q <= gdrc_pkg::ONE_SHL32;
						div_den_q <= SW'(mag_y);
						div_go_q  <= 1'b1;
						state_q   <= S_DYW;
					end
				end
				S_DYW: begin
					if (div_done) begin
						delta_y_q <= div_quot;
						state_q   <= S_SIDE;
					end
				end
				S_SIDE: begin
					side_x_q <= SW'((50'(f_x) * 50'(delta_x_q)) >> 16);
					side_y_q <= SW'((50'(f_y) * 50'(delta_y_q)) >> 16);
					mx_q     <= CW'({1'b0, cfg.pos_x[20:16]});
					my_q     <= CW'({1'b0, cfg.pos_y[20:16]});
					steps_q  <= '0;
					state_q  <= S_STEP;
				end
				S_STEP: begin
					// advance the nearer axis, y on a tie; map read is in flight
					if (adv_x)
						side_x_q <= side_x_q + SW'(delta_x_q);
					else
						side_y_q <= side_y_q + SW'(delta_y_q);
					mx_q    <= nx;
					my_q    <= ny;
					side_q  <= !adv_x;
					inr_q   <= in_range;
					steps_q <= steps_q + 1'b1;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (inr_q && rdata_q != 3'd0) begin
						code_q  <= rdata_q;
						state_q <= S_PERP;
					end else if (32'(steps_q) == MAX_STEPS) begin
						res_q   <= '{out_column: column_q, stripe_top: 10'd0,
						             stripe_bottom: 10'd0, wall_colour: 24'd0,
						             hit_side: 1'b0, no_hit: 1'b1};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_PERP: begin
					if (perp == '0) begin
						line_q  <= gdrc_pkg::LINE_MAX;
						state_q <= S_FIN;
					end else begin
						div_num_q <= NW'({rows_eff, 16'd0});
						div_den_q <= perp;
						div_go_q  <= 1'b1;
						state_q   <= S_LINE;
					end
				end
				S_LINE: begin
					if (div_done) begin
						line_q  <= (div_quot > NW'(gdrc_pkg::LINE_MAX)) ?
						           gdrc_pkg::LINE_MAX : div_quot[15:0];
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					res_q   <= '{out_column: column_q, stripe_top: top_v,
					             stripe_bottom: bot_v, wall_colour: colour,
					             hit_side: side_q, no_hit: 1'b0};
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign bk_stat.clearing = state_q == S_CLEAR;
	assign bk_stat.pop      = state_q == S_IDLE;
	assign done   = done_q;
	assign result = res_q;
endmodule
`default_nettype wire

### src/grid_dda_column_raycaster_core.sv
// Top level of the grid DDA column raycaster: configuration registers, front
// end queue and back end cast engine. Uses gdrc_pkg, gdrc_front, gdrc_back.
//
//   channel   signals                             accepted when
//   input     start, busy, item                   start && !busy
//   result    done, result                        every cycle done is high
//   config    cfg_valid, cfg_ready, cfg_index,    cfg_valid && cfg_ready
//             cfg_data
//
// A kept item is written into the queue registers first. A map write is then
// done by the back end in its idle state. A cast runs four divider passes
// (camera offset, two step lengths, stripe height; a zero ray component skips
// its pass) and DDA steps up to MAX_STEPS, each a step and a check state.
// After reset a clearing pass zeroes every map cell; busy stays high meanwhile.
// A two-entry queue lets two items wait behind a cast. Each result shows for
// one cycle; the receiver cannot stall it.
`default_nettype none
module grid_dda_column_raycaster_core #(
	parameter int MAP_DIM   = gdrc_pkg::MAP_DIM_DEF,
	parameter int MAX_STEPS = gdrc_pkg::MAX_STEPS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire gdrc_pkg::item_t   item,
	output logic                   done,
	output gdrc_pkg::result_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [3:0]        cfg_index,
	input  wire logic [31:0]       cfg_data
);
	gdrc_pkg::cfg_t     cfg_q;
	gdrc_pkg::bk_stat_t bk_stat;
	logic               q_valid;
	gdrc_pkg::item_t    q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x   <= gdrc_pkg::RST_POS_X;
			cfg_q.pos_y   <= gdrc_pkg::RST_POS_Y;
			cfg_q.dir_x   <= gdrc_pkg::RST_DIR_X;
			cfg_q.dir_y   <= gdrc_pkg::RST_DIR_Y;
			cfg_q.plane_x <= gdrc_pkg::RST_PLANE_X;
			cfg_q.plane_y <= gdrc_pkg::RST_PLANE_Y;
			cfg_q.cols    <= gdrc_pkg::RST_COLS;
			cfg_q.rows    <= gdrc_pkg::RST_ROWS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gdrc_pkg::REG_POS_X:   cfg_q.pos_x   <= cfg_data[20:0];
				gdrc_pkg::REG_POS_Y:   cfg_q.pos_y   <= cfg_data[20:0];
				gdrc_pkg::REG_DIR_X:   cfg_q.dir_x   <= cfg_data[18:0];
				gdrc_pkg::REG_DIR_Y:   cfg_q.dir_y   <= cfg_data[18:0];
				gdrc_pkg::REG_PLANE_X: cfg_q.plane_x <= cfg_data[18:0];
				gdrc_pkg::REG_PLANE_Y: cfg_q.plane_y <= cfg_data[18:0];
				gdrc_pkg::REG_COLS:    cfg_q.cols    <= cfg_data[10:0];
				gdrc_pkg::REG_ROWS:    cfg_q.rows    <= cfg_data[10:0];
				default: ; // drop writes past the register list
			endcase
		end
	end

	gdrc_front #(.MAP_DIM(MAP_DIM)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.bk_stat(bk_stat),
		.q_valid(q_valid),
		.q_item (q_item)
	);

	gdrc_back #(.MAP_DIM(MAP_DIM), .MAX_STEPS(MAX_STEPS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_valid(q_valid),
		.q_item (q_item),
		.bk_stat(bk_stat),
		.done   (done),
		.result (result)
	);
endmodule
`default_nettype wire

### src/gdrc_chk.sv
// Port-level checker for the raycaster core and its bind statement.
// Depends on gdrc_pkg (result_t).
`default_nettype none
module gdrc_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              done,
	input wire gdrc_pkg::result_t result
);
	// a cast spans many cycles, so results never come back to back
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("results on consecutive cycles");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.no_hit) |-> (result.stripe_top == 10'd0 &&
		 result.stripe_bottom == 10'd0 && result.wall_colour == 24'd0 &&
		 result.hit_side == 1'b0)) else $error("miss carries nonzero fields");

	a_stripe_order: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.no_hit) |-> result.stripe_top <= result.stripe_bottom)
		else $error("stripe top below bottom");

	a_yside_dim: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.no_hit && result.hit_side) |-> !result.wall_colour[23])
		else $error("y-side colour not halved");
endmodule

bind grid_dda_column_raycaster_core gdrc_chk u_chk (
	.clk   (clk),
	.arst_n(arst_n),
	.done  (done),
	.result(result)
);
`default_nettype wire

### tb/grid_dda_column_raycaster_core_tb.sv
// Self-checking testbench for grid_dda_column_raycaster_core: map writes and
// column casts are predicted in the bench and compared result by result.
// Depends on gdrc_pkg and the core RTL only.
`timescale 1ns / 100ps
`default_nettype none
module grid_dda_column_raycaster_core_tb;

	localparam int          GRID       = 32;
	localparam int          STEP_CAP   = 64;
	localparam int          STALL_MAX  = 5000;
	localparam int          DRAIN_WAIT = 200;
	localparam logic [3:0]  IDX_TOP    = 4'd15;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	gdrc_pkg::item_t     item = '0;
	logic                done;
	gdrc_pkg::result_t   result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [3:0]          cfg_index = '0;
	logic [31:0]         cfg_data = '0;

	gdrc_pkg::cfg_t      cam_cfg;
	logic [2:0]          map_copy [GRID*GRID];
	gdrc_pkg::result_t   pending_casts [$];
	int                  errors = 0;
	int                  quiet_cycles = 0;
	int                  gap_pct = 0;

	grid_dda_column_raycaster_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic longint unsigned step_len(input longint r);
		longint unsigned m;
		m = (r < 0) ? longint'(-r) : longint'(r);
		return (m == 0) ? 64'h1_0000_0000 : 64'h1_0000_0000 / m;
	endfunction

	function automatic logic [23:0] code_rgb(input logic [2:0] code);
		case (code)
			3'd1: return 24'hFF0000;
			3'd2: return 24'h32CD32;
			3'd3: return 24'h0000FF;
			3'd0, 3'd4: return 24'h000000;
			default: return 24'hFFFF00;
		endcase
	endfunction

	function automatic gdrc_pkg::result_t cast_column(input logic [9:0] col);
		longint unsigned cols, rows, dx, dy, sdx, sdy, fx, fy, perp, line;
		longint cam, rx, ry, top, bot;
		int mx, my, stx, sty;
		logic yside;
		logic [2:0] code;
		logic [23:0] rgb;
		gdrc_pkg::result_t r;
		cols = 64'(cam_cfg.cols);
		if (cols == 0) cols = 1;
		rows = 64'(cam_cfg.rows);
		if (rows == 0) rows = 1;
		if (rows > 1024) rows = 1024;
		cam = longint'((64'(col) * 131072) / cols) - 65536;
		rx = longint'(cam_cfg.dir_x) + (longint'(cam_cfg.plane_x) * cam) / 65536;
		ry = longint'(cam_cfg.dir_y) + (longint'(cam_cfg.plane_y) * cam) / 65536;
		dx = step_len(rx);
		dy = step_len(ry);
		fx = 64'(cam_cfg.pos_x[15:0]);
		fy = 64'(cam_cfg.pos_y[15:0]);
		mx = int'(cam_cfg.pos_x[20:16]);
		my = int'(cam_cfg.pos_y[20:16]);
		stx = (rx < 0) ? -1 : 1;
		sty = (ry < 0) ? -1 : 1;
		sdx = ((rx < 0) ? fx * dx : (65536 - fx) * dx) >> 16;
		sdy = ((ry < 0) ? fy * dy : (65536 - fy) * dy) >> 16;
		code = 3'd0;
		yside = 1'b0;
		for (int k = 0; k < STEP_CAP; k++) begin
			// tie goes to y
			if (sdx < sdy) begin
				sdx += dx;
				mx += stx;
				yside = 1'b0;
			end else begin
				sdy += dy;
				my += sty;
				yside = 1'b1;
			end
			if (mx >= 0 && my >= 0 && mx < GRID && my < GRID)
				code = map_copy[mx*GRID + my];
			else
				code = 3'd0;
			if (code != 0) break;
		end
		r = '0;
		r.out_column = col;
		if (code == 0) begin
			r.no_hit = 1'b1;
			return r;
		end
		perp = yside ? sdy - dy : sdx - dx;
		if (perp == 0) line = 65535;
		else begin
			line = (rows << 16) / perp;
			if (line > 65535) line = 65535;
		end
		top = longint'(rows / 2) - longint'(line / 2);
		if (top < 0) top = 0;
		bot = longint'(rows / 2) + longint'(line / 2);
		if (bot >= longint'(rows)) bot = longint'(rows) - 1;
		rgb = code_rgb(code);
		if (yside) rgb = rgb >> 1;
		r.stripe_top = top[9:0];
		r.stripe_bottom = bot[9:0];
		r.wall_colour = rgb;
		r.hit_side = yside;
		return r;
	endfunction

	// checker and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_MAX) begin
				$display("%0t timeout: no handshake for %0d cycles", $time, STALL_MAX);
				$display("CHECKS FAILED");
				$finish;
			end
			if (done) begin
				if (pending_casts.size() == 0) begin
					$display("%0t unexpected result %p", $time, result);
					errors++;
				end else begin
					gdrc_pkg::result_t want;
					want = pending_casts.pop_front();
					if (result !== want) begin
						$display("%0t mismatch col %0d: expected %p actual %p",
							$time, want.out_column, want, result);
						errors++;
					end
				end
			end
		end
	end

	task automatic send_item(input gdrc_pkg::item_t it);
		int gap;
		gap = 0;
		while ($urandom_range(99) < gap_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		if (it.cmd == gdrc_pkg::CMD_CAST)
			pending_casts.push_back(cast_column(it.column));
		else
			map_copy[{it.cell_x, it.cell_y}] = it.cell_code;
	endtask

	task automatic put_cell(input int x, input int y, input logic [2:0] code);
		gdrc_pkg::item_t it;
		it = '0;
		it.cmd = gdrc_pkg::CMD_WRITE;
		it.cell_x = 5'(x);
		it.cell_y = 5'(y);
		it.cell_code = code;
		it.column = 10'($urandom);
		send_item(it);
	endtask

	task automatic cast(input logic [9:0] col);
		gdrc_pkg::item_t it;
		it = 24'($urandom);
		it.cmd = gdrc_pkg::CMD_CAST;
		it.column = col;
		send_item(it);
	endtask

	// hold config writes until the core has drained
	task automatic drain();
		start <= 1'b0;
		while (pending_casts.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			gdrc_pkg::REG_POS_X:   cam_cfg.pos_x = data[20:0];
			gdrc_pkg::REG_POS_Y:   cam_cfg.pos_y = data[20:0];
			gdrc_pkg::REG_DIR_X:   cam_cfg.dir_x = data[18:0];
			gdrc_pkg::REG_DIR_Y:   cam_cfg.dir_y = data[18:0];
			gdrc_pkg::REG_PLANE_X: cam_cfg.plane_x = data[18:0];
			gdrc_pkg::REG_PLANE_Y: cam_cfg.plane_y = data[18:0];
			gdrc_pkg::REG_COLS:    cam_cfg.cols = data[10:0];
			gdrc_pkg::REG_ROWS:    cam_cfg.rows = data[10:0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] rand_q2();
		// mostly in range, upper bits random so every data bit toggles
		return {$urandom_range(8191) << 19} | 32'(19'($urandom_range(262144) - 131072));
	endfunction

	task automatic test_empty_map();
		cast(10'd0);
		cast(10'd1023);
		cast(10'd300);
	endtask

	task automatic test_walls_default_view();
		for (int i = 0; i < GRID; i += 31) begin
			put_cell(i, 5, 3'd1);
			put_cell(5, i, 3'd7);
		end
		put_cell(0, 12, 3'd2);
		put_cell(31, 31, 3'd5);
		for (int c = 0; c <= 10; c++) put_cell(c, c + 7, 3'(c % 8));
		cast(10'd0);
		cast(10'd299);
		cast(10'd599);
		cast(10'd1023);
	endtask

	task automatic test_config_extremes();
		drain();
		write_reg(gdrc_pkg::REG_COLS, 32'd0);
		write_reg(gdrc_pkg::REG_ROWS, 32'd0);
		write_reg(gdrc_pkg::REG_DIR_X, 32'd0);
		write_reg(gdrc_pkg::REG_PLANE_Y, 32'd0);
		write_reg(gdrc_pkg::REG_DIR_Y, 32'd131072);
		cast(10'd0);
		cast(10'd1023);
		drain();
		write_reg(gdrc_pkg::REG_ROWS, 32'd2047);
		write_reg(gdrc_pkg::REG_COLS, 32'd1024);
		write_reg(gdrc_pkg::REG_DIR_Y, 32'hFFFE_0000);
		write_reg(gdrc_pkg::REG_PLANE_X, 32'd131072);
		write_reg(gdrc_pkg::REG_POS_X, 32'h001F_FFFF);
		write_reg(gdrc_pkg::REG_POS_Y, 32'd0);
		write_reg(4'($urandom_range(IDX_TOP, gdrc_pkg::REG_ROWS + 1)), $urandom);
		cast(10'd0);
		cast(10'd512);
		cast(10'd1023);
		drain();
		write_reg(gdrc_pkg::REG_PLANE_X, 32'hFFFE_0000);
		write_reg(gdrc_pkg::REG_POS_X, 32'h0010_8000);
		write_reg(gdrc_pkg::REG_POS_Y, 32'h000F_FFFF);
		write_reg(gdrc_pkg::REG_ROWS, 32'd1);
		cast(10'd700);
	endtask

	task automatic test_random(input int pct, input int n);
		gap_pct = pct;
		drain();
		write_reg(gdrc_pkg::REG_POS_X, $urandom);
		write_reg(gdrc_pkg::REG_POS_Y, $urandom);
		write_reg(gdrc_pkg::REG_DIR_X, rand_q2());
		write_reg(gdrc_pkg::REG_DIR_Y, rand_q2());
		write_reg(gdrc_pkg::REG_PLANE_X, rand_q2());
		write_reg(gdrc_pkg::REG_PLANE_Y, rand_q2());
		write_reg(gdrc_pkg::REG_COLS,
			($urandom_range(3) == 0) ? $urandom : $urandom_range(1024, 1));
		write_reg(gdrc_pkg::REG_ROWS,
			($urandom_range(3) == 0) ? $urandom : $urandom_range(1024, 1));
		// refresh part of the border so most rays still land on a wall
		for (int i = 0; i < GRID; i++) begin
			if ($urandom_range(3) == 0) put_cell(i, 0, 3'($urandom_range(7, 1)));
			if ($urandom_range(3) == 0) put_cell(i, 31, 3'($urandom_range(7, 1)));
			if ($urandom_range(3) == 0) put_cell(0, i, 3'($urandom_range(7, 1)));
			if ($urandom_range(3) == 0) put_cell(31, i, 3'($urandom_range(7, 1)));
		end
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(9) < 3)
				put_cell($urandom, $urandom,
					($urandom_range(2) == 0) ? 3'd0 : 3'($urandom));
			else if ($urandom_range(9) == 0)
				cast(10'($urandom));
			else
				cast(10'($urandom_range((cam_cfg.cols == 0) ? 0 : cam_cfg.cols - 1, 0)));
		end
	endtask

	initial begin
		cam_cfg = '{gdrc_pkg::RST_POS_X, gdrc_pkg::RST_POS_Y, gdrc_pkg::RST_DIR_X,
			gdrc_pkg::RST_DIR_Y, gdrc_pkg::RST_PLANE_X, gdrc_pkg::RST_PLANE_Y,
			gdrc_pkg::RST_COLS, gdrc_pkg::RST_ROWS};
		foreach (map_copy[i]) map_copy[i] = 3'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_map();
		test_walls_default_view();
		test_config_extremes();
		for (int p = 0; p < 2; p++) test_random(26, 100);
		for (int p = 0; p < 2; p++) test_random(46, 100);
		for (int p = 0; p < 2; p++) test_random(0, 100);
		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire
